// ----- rtl/sliding_window_aggregator_assert.svh -----
// Assertion macros for the sliding window aggregator checker.
// Each macro expects clock and reset ports in the module that uses it.
`ifndef SLIDING_WINDOW_AGGREGATOR_ASSERT_SVH
`define SLIDING_WINDOW_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/swa_pkg.sv -----
// Shared types, codes and combine functions for the sliding window aggregator.
// No dependencies; imported by every module of the block.
package swa_pkg;

   localparam int AGG_W      = 40;
   localparam int SAMPLE_W   = 32;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic signed [AGG_W-1:0] AGG_MAX = {1'b0, {(AGG_W-1){1'b1}}};
   localparam logic signed [AGG_W-1:0] AGG_MIN = {1'b1, {(AGG_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMBINE_MODE = 1'd0,
      CSR_WINDOW_SIZE  = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_SUM = 2'd0,
      MODE_MIN = 2'd1,
      MODE_MAX = 2'd2
   } mode_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_EVICT  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ACCUM,
      SEQ_LEFT,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [AGG_W-1:0] aggregate;
      logic [COUNT_W-1:0]      count;
      status_type              status;
   } rsp_type;

   // Configuration seen by the sequencer; mode already carries a write in progress
   typedef struct packed {
      logic               clear;
      logic [1:0]         mode;
      logic [COUNT_W-1:0] ring_len;
   } ctl_type;

   function automatic logic signed [AGG_W-1:0] agg_identity(input logic [1:0] mode);
      logic signed [AGG_W-1:0] r;
      case (mode)
         MODE_MIN: r = AGG_MAX;
         MODE_MAX: r = AGG_MIN;
         default:  r = '0;
      endcase
      return r;
   endfunction

   // Unused mode code falls back to sum
   function automatic logic signed [AGG_W-1:0] agg_combine(
      input logic [1:0]              mode,
      input logic signed [AGG_W-1:0] x,
      input logic signed [AGG_W-1:0] y
   );
      logic signed [AGG_W:0]   s;
      logic signed [AGG_W-1:0] r;
      s = {x[AGG_W-1], x} + {y[AGG_W-1], y};
      case (mode)
         MODE_MIN: r = (x < y) ? x : y;
         MODE_MAX: r = (x > y) ? x : y;
         default: begin
            if (s[AGG_W] != s[AGG_W-1]) begin
               r = s[AGG_W] ? AGG_MIN : AGG_MAX;
            end else begin
               r = s[AGG_W-1:0];
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/swa_store.sv -----
// Partial aggregate store: one write port, two registered read ports.
// Write-first: a read of the address being written returns the new data. Uses swa_pkg.
module swa_store
   import swa_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [$clog2(DEPTH)-1:0]      waddr,
   input  logic signed [AGG_W-1:0]       wdata,
   input  logic [$clog2(DEPTH)-1:0]      raddr_a,
   input  logic [$clog2(DEPTH)-1:0]      raddr_b,
   output logic signed [AGG_W-1:0]       rdata_a,
   output logic signed [AGG_W-1:0]       rdata_b
);

   logic [AGG_W-1:0] store_ff [DEPTH];
   logic [AGG_W-1:0] rdata_a_ff;
   logic [AGG_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_a_ff <= (we && (waddr == raddr_a)) ? wdata : store_ff[raddr_a];
      rdata_b_ff <= (we && (waddr == raddr_b)) ? wdata : store_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ----- rtl/swa_seq.sv -----
// Sequencer for the sliding window: pointers, running sums, the per-item
// read-modify-write steps on the store, and the result register. Uses swa_pkg.
module swa_seq
   import swa_pkg::*;
#(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ctl_type                           ctl,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_type                           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rsp_type                           rsp_data,
   output logic                              mem_we,
   output logic [$clog2(MAX_WINDOW)-1:0]     mem_waddr,
   output logic signed [AGG_W-1:0]           mem_wdata,
   output logic [$clog2(MAX_WINDOW)-1:0]     mem_raddr_a,
   output logic [$clog2(MAX_WINDOW)-1:0]     mem_raddr_b,
   input  logic signed [AGG_W-1:0]           mem_rdata_a,
   input  logic signed [AGG_W-1:0]           mem_rdata_b
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(
      input logic [PTR_W-1:0]   p,
      input logic [COUNT_W-1:0] len
   );
      logic [COUNT_W-1:0] nxt;
      nxt = COUNT_W'(p) + COUNT_W'(1);
      return (nxt >= len) ? '0 : PTR_W'(nxt);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(
      input logic [PTR_W-1:0]   p,
      input logic [COUNT_W-1:0] len
   );
      return (p == '0) ? PTR_W'(len - COUNT_W'(1)) : p - PTR_W'(1);
   endfunction

   seq_state_type           state_ff, state_in;
   logic [PTR_W-1:0]        front_ff, front_in;
   logic [PTR_W-1:0]        left_ff, left_in;
   logic [PTR_W-1:0]        right_ff, right_in;
   logic [PTR_W-1:0]        accum_ff, accum_in;
   logic [PTR_W-1:0]        boundary_ff, boundary_in;
   logic [PTR_W-1:0]        end_ff, end_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [AGG_W-1:0] middle_ff, middle_in;
   logic signed [AGG_W-1:0] back_ff, back_in;
   logic                    adv_ff, adv_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Front-end values of an accepted item: the insert/evict step, then the flip
   logic                    is_ins;
   logic                    reject;
   logic                    flip;
   logic signed [AGG_W-1:0] ident;
   logic signed [AGG_W-1:0] sample_ext;
   logic signed [AGG_W-1:0] back_s;
   logic [PTR_W-1:0]        front_s, end_s;
   logic [CNT_W-1:0]        count_s;
   logic [PTR_W-1:0]        left_f, right_f, accum_f, boundary_f;
   logic signed [AGG_W-1:0] middle_f, back_f;

   // Back-end working values
   logic                    acc_en;
   logic [PTR_W-1:0]        accum_a;
   logic [PTR_W-1:0]        accum_nxt;
   logic signed [AGG_W-1:0] delta;
   logic signed [AGG_W-1:0] alpha;

   assign ident      = agg_identity(ctl.mode);
   assign sample_ext = {{(AGG_W-SAMPLE_BITS){req_data.sample[SAMPLE_BITS-1]}},
                        req_data.sample[SAMPLE_BITS-1:0]};

   always_comb begin
      is_ins  = (req_data.op == OP_INSERT);
      reject  = is_ins ? (COUNT_W'(count_ff) >= ctl.ring_len) : (count_ff == '0);
      back_s  = is_ins ? agg_combine(ctl.mode, back_ff, sample_ext) : back_ff;
      end_s   = is_ins ? ptr_inc(end_ff, ctl.ring_len) : end_ff;
      front_s = is_ins ? front_ff : ptr_inc(front_ff, ctl.ring_len);
      count_s = is_ins ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
      flip       = (left_ff == boundary_ff);
      left_f     = flip ? front_s     : left_ff;
      right_f    = flip ? boundary_ff : right_ff;
      accum_f    = flip ? end_s       : accum_ff;
      boundary_f = flip ? end_s       : boundary_ff;
      middle_f   = flip ? back_s      : middle_ff;
      back_f     = flip ? ident       : back_s;
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      accum_in     = accum_ff;
      boundary_in  = boundary_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      middle_in    = middle_ff;
      back_in      = back_ff;
      adv_in       = adv_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = (state_ff == SEQ_IDLE);
      mem_we       = 1'b0;
      mem_waddr    = end_ff;
      mem_wdata    = sample_ext;
      mem_raddr_a  = front_ff;
      mem_raddr_b  = front_ff;
      acc_en       = adv_ff && (accum_ff != right_ff);
      accum_a      = ptr_dec(accum_ff, ctl.ring_len);
      accum_nxt    = ptr_inc(accum_ff, ctl.ring_len);
      delta        = (accum_ff == boundary_ff) ? ident : mem_rdata_a;
      alpha        = ((boundary_ff == front_ff) && (COUNT_W'(count_ff) != ctl.ring_len))
                     ? ident : mem_rdata_a;

      case (state_ff)
         SEQ_IDLE: begin
            // Fetch delta and the entry below it for the accumulator fold
            mem_raddr_a = accum_f;
            mem_raddr_b = ptr_dec(accum_f, ctl.ring_len);
            if (req_valid) begin
               state_in = SEQ_ACCUM;
               adv_in   = 1'b0;
               if (reject) begin
                  status_in = is_ins ? STATUS_FULL : STATUS_EMPTY;
               end else begin
                  status_in   = STATUS_DONE;
                  mem_we      = is_ins;
                  end_in      = end_s;
                  front_in    = front_s;
                  count_in    = count_s;
                  left_in     = left_f;
                  right_in    = right_f;
                  accum_in    = accum_f;
                  boundary_in = boundary_f;
                  middle_in   = middle_f;
                  back_in     = back_f;
                  adv_in      = (count_s != '0);
                  if (count_s == '0) begin
                     middle_in = ident;
                     back_in   = ident;
                  end
               end
            end
         end
         SEQ_ACCUM: begin
            if (acc_en) begin
               mem_we    = 1'b1;
               mem_waddr = accum_a;
               mem_wdata = agg_combine(ctl.mode, mem_rdata_b, delta);
               accum_in  = accum_a;
            end
            mem_raddr_a = left_ff;
            // entry above the accumulator once this fold is done
            mem_raddr_b = acc_en ? accum_ff : accum_nxt;
            state_in    = SEQ_LEFT;
         end
         SEQ_LEFT: begin
            if (adv_ff) begin
               left_in = ptr_inc(left_ff, ctl.ring_len);
               if (left_ff != right_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = left_ff;
                  mem_wdata = agg_combine(ctl.mode, mem_rdata_a, middle_ff);
               end else begin
                  right_in  = ptr_inc(right_ff, ctl.ring_len);
                  accum_in  = accum_nxt;
                  middle_in = (accum_nxt == boundary_ff) ? ident : mem_rdata_b;
               end
            end
            state_in = SEQ_FINISH;
         end
         SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.aggregate = (count_ff == '0) ? ident
                                       : agg_combine(ctl.mode, alpha, back_ff);
               rsp_data_in.count     = COUNT_W'(count_ff);
               rsp_data_in.status    = status_ff;
               state_in              = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      // A register write empties the window
      if (ctl.clear) begin
         front_in    = '0;
         left_in     = '0;
         right_in    = '0;
         accum_in    = '0;
         boundary_in = '0;
         end_in      = '0;
         count_in    = '0;
         middle_in   = ident;
         back_in     = ident;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         front_ff     <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         accum_ff     <= '0;
         boundary_ff  <= '0;
         end_ff       <= '0;
         count_ff     <= '0;
         middle_ff    <= '0;
         back_ff      <= '0;
         adv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         accum_ff     <= accum_in;
         boundary_ff  <= boundary_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         middle_ff    <= middle_in;
         back_ff      <= back_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/sliding_window_aggregator.sv -----
// After its request transfer, an item takes the accumulator fold and the left fold, each a
// read-modify-write through the one write port of the partial store, then the front read,
// and its result is registered from the finish state; a new request is taken only in idle.
// A result waiting for rsp_ready does not block the next request transfer.
// Reset (synchronous): empty window, mode sum, window of MAX_WINDOW; the store is not cleared.
module sliding_window_aggregator
   import swa_pkg::*;
#(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(MAX_WINDOW);

   logic [1:0]              mode_ff, mode_in;
   logic [COUNT_W-1:0]      ring_ff, ring_in;
   logic                    clear;
   ctl_type                 ctl;

   logic                    mem_we;
   logic [PTR_W-1:0]        mem_waddr;
   logic signed [AGG_W-1:0] mem_wdata;
   logic [PTR_W-1:0]        mem_raddr_a;
   logic [PTR_W-1:0]        mem_raddr_b;
   logic signed [AGG_W-1:0] mem_rdata_a;
   logic signed [AGG_W-1:0] mem_rdata_b;

   always_comb begin
      mode_in = mode_ff;
      ring_in = ring_ff;
      clear   = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_COMBINE_MODE: begin
               mode_in = csr_wdata[1:0];
               clear   = 1'b1;
            end
            CSR_WINDOW_SIZE: begin
               if (csr_wdata == '0) begin
                  ring_in = COUNT_W'(1);
               end else if (csr_wdata > COUNT_W'(MAX_WINDOW)) begin
                  ring_in = COUNT_W'(MAX_WINDOW);
               end else begin
                  ring_in = csr_wdata;
               end
               clear = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUM;
         ring_ff <= COUNT_W'(MAX_WINDOW);
      end else begin
         mode_ff <= mode_in;
         ring_ff <= ring_in;
      end
   end

   // mode_in so that clearing takes the identity of a newly written operator
   assign ctl = {clear, mode_in, ring_ff};

   swa_store #(
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   swa_seq #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b)
   );

endmodule

// ----- rtl/swa_checker.sv -----
// Port-level checks for the sliding window aggregator, bound to the top level.
// Uses swa_pkg and the macros in sliding_window_aggregator_assert.svh.
`include "sliding_window_aggregator_assert.svh"

module swa_checker
   import swa_pkg::*;
#(
   parameter int MAX_WINDOW = 256
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one item in flight: no second transfer straight after the first
   `SWA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

   `SWA_ASSERT_IMPLY(a_count_bound, rsp_valid, rsp_data.count <= COUNT_W'(MAX_WINDOW), "count above window limit")

   `SWA_ASSERT_IMPLY(a_empty_status, rsp_valid && (rsp_data.status == STATUS_EMPTY), rsp_data.count == '0, "empty evict with entries left")

   `SWA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind sliding_window_aggregator swa_checker #(
   .MAX_WINDOW (MAX_WINDOW)
) u_swa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
